FILE: rtl/csm_pkg.sv
package csm_pkg;

  // Number of mixer channels and of spoiler channels.
  localparam int NCH = 4;

  // Register stages from input capture to the output register.
  localparam int NSTG = 11;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIXING_GAIN   = 3'd0,
    REG_MIXING_OFFSET = 3'd1,
    REG_RUDDER_RATE   = 3'd2,
    REG_CROW_OUTER    = 3'd3,
    REG_CROW_INNER    = 3'd4,
    REG_SPOILER_EN    = 3'd5
  } cfg_reg_t;

  typedef logic signed [13:0] cmd_t;
  typedef logic signed [19:0] sp_t;
  typedef logic signed [21:0] sp_wide_t;
  typedef logic signed [37:0] prod_t;

  // Output limit in centidegrees and in hundredths of a centidegree.
  localparam cmd_t LIMIT_CD = 14'sd4500;
  localparam sp_t  LIMIT_SP = 20'sd450000;

  // A scaled product at or beyond 4501 * 100 * 1024 saturates the output.
  localparam prod_t SAT_HI = 38'sd460902400;

  // floor(n / 100) = (n * RECIP_100) >> RECIP_SHIFT for n below about 1.8 million.
  localparam logic [19:0] RECIP_100 = 20'd671089;
  localparam int RECIP_SHIFT = 26;

  localparam logic [12:0] CROW_NUM = 13'd45;

  function automatic logic [12:0] div100(input logic [18:0] n);
    logic [38:0] p;
    p = 39'(n) * 39'(RECIP_100);
    return p[RECIP_SHIFT+12:RECIP_SHIFT];
  endfunction

  function automatic sp_t clamp_sp(input sp_wide_t v);
    sp_t res;
    if (v > sp_wide_t'(LIMIT_SP)) begin
      res = LIMIT_SP;
    end else if (v < -sp_wide_t'(LIMIT_SP)) begin
      res = -LIMIT_SP;
    end else begin
      res = v[19:0];
    end
    return res;
  endfunction

endpackage

FILE: rtl/control_surface_mixer.sv
// Elevon, V-tail and differential spoiler mixer. Each input beat carries one
// aileron, elevator and rudder command (centidegrees) and a flap percentage;
// each one produces exactly one output beat with the two elevons, the two
// V-tail surfaces and four differential spoilers, every value clamped to
// +/-4500 and truncated toward zero. The block is an eleven stage pipeline:
// the result of a beat passes through every stage register on its way to
// the output, and a new beat is taken in every cycle unless back-pressure
// has filled the pipeline. Each stage holds its own valid bit and advances
// whenever it is empty or the stage after it advances, so bubbles are
// squeezed out and a stalled output still lets upstream stages fill. The
// stage depth is set by the 14x11 offset multipliers, the 26x12 gain
// multipliers and the reciprocal multipliers that divide by one hundred.
// Configuration registers are written through the cfg port (always ready)
// and must only change while the pipeline is empty.
module control_surface_mixer (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [13:0] in_aileron_cmd,
  input  logic signed [13:0] in_elevator_cmd,
  input  logic signed [13:0] in_rudder_cmd,
  input  logic signed [7:0]  in_flap_pct,

  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [13:0] out_left_elevon,
  output logic signed [13:0] out_right_elevon,
  output logic signed [13:0] out_vtail_left,
  output logic signed [13:0] out_vtail_right,
  output logic signed [13:0] out_spoiler_left_outer,
  output logic signed [13:0] out_spoiler_left_inner,
  output logic signed [13:0] out_spoiler_right_outer,
  output logic signed [13:0] out_spoiler_right_inner,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [csm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [csm_pkg::CFG_DATA_W-1:0] cfg_data
);

  // ---------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------
  logic [11:0]        cfg_gain_r;
  logic signed [10:0] cfg_offset_r;
  logic [6:0]         cfg_rate_r;
  logic [6:0]         cfg_wo_r;
  logic [6:0]         cfg_wi_r;
  logic               cfg_sp_en_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_gain_r   <= 12'd512;
      cfg_offset_r <= 11'sd0;
      cfg_rate_r   <= 7'd100;
      cfg_wo_r     <= 7'd0;
      cfg_wi_r     <= 7'd0;
      cfg_sp_en_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        csm_pkg::REG_MIXING_GAIN:   cfg_gain_r   <= cfg_data[11:0];
        csm_pkg::REG_MIXING_OFFSET: cfg_offset_r <= $signed(cfg_data[10:0]);
        csm_pkg::REG_RUDDER_RATE:   cfg_rate_r   <= cfg_data[6:0];
        csm_pkg::REG_CROW_OUTER:    cfg_wo_r     <= cfg_data[6:0];
        csm_pkg::REG_CROW_INNER:    cfg_wi_r     <= cfg_data[6:0];
        csm_pkg::REG_SPOILER_EN:    cfg_sp_en_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control. A stage loads when it is empty or its contents move
  // on; the last stage is the output register.
  // ---------------------------------------------------------------------
  logic [csm_pkg::NSTG-1:0] v_r;
  logic [csm_pkg::NSTG-1:0] en;

  always_comb begin
    en[csm_pkg::NSTG-1] = !v_r[csm_pkg::NSTG-1] || out_ready;
    for (int i = csm_pkg::NSTG - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[csm_pkg::NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < csm_pkg::NSTG; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: offset scaling. A negative offset stretches the elevator, a
  // positive one the aileron and rudder. The rudder share for the spoilers
  // and the flap crow factor are formed here as well; flap at or below zero
  // gives no crow term at all.
  // ---------------------------------------------------------------------
  logic [10:0]        ke, kx;
  logic signed [24:0] s1_em_nxt, s1_am_nxt, s1_rm_nxt;
  logic signed [20:0] s1_rsp_nxt;
  logic [12:0]        s1_f45_nxt;
  logic signed [24:0] s1_em_r, s1_am_r, s1_rm_r;
  logic signed [20:0] s1_rsp_r;
  logic [12:0]        s1_f45_r;

  always_comb begin
    ke = cfg_offset_r[10] ? 11'(11'sd100 - cfg_offset_r) : 11'd100;
    kx = (!cfg_offset_r[10] && cfg_offset_r != 11'sd0) ?
         11'(11'sd100 + cfg_offset_r) : 11'd100;
    s1_em_nxt  = in_elevator_cmd * $signed({1'b0, ke});
    s1_am_nxt  = in_aileron_cmd * $signed({1'b0, kx});
    s1_rm_nxt  = in_rudder_cmd * $signed({1'b0, kx});
    s1_rsp_nxt = in_rudder_cmd * $signed({1'b0, cfg_rate_r});
    if (!in_flap_pct[7] && in_flap_pct != 8'sd0) begin
      s1_f45_nxt = 13'(in_flap_pct[6:0]) * csm_pkg::CROW_NUM;
    end else begin
      s1_f45_nxt = 13'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_em_r  <= s1_em_nxt;
      s1_am_r  <= s1_am_nxt;
      s1_rm_r  <= s1_rm_nxt;
      s1_rsp_r <= s1_rsp_nxt;
      s1_f45_r <= s1_f45_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: mixer sums in channel order elevon left, elevon right,
  // V-tail left, V-tail right, and the two crow terms.
  // ---------------------------------------------------------------------
  logic signed [25:0] s2_mix_nxt [csm_pkg::NCH];
  logic signed [25:0] s2_mix_r   [csm_pkg::NCH];
  logic [19:0]        s2_fo_nxt, s2_fi_nxt, s2_fo_r, s2_fi_r;
  logic signed [20:0] s2_rsp_r;

  always_comb begin
    s2_mix_nxt[0] = 26'(s1_em_r) - 26'(s1_am_r);
    s2_mix_nxt[1] = 26'(s1_em_r) + 26'(s1_am_r);
    s2_mix_nxt[2] = 26'(s1_em_r) + 26'(s1_rm_r);
    s2_mix_nxt[3] = 26'(s1_em_r) - 26'(s1_rm_r);
    s2_fo_nxt     = 20'(s1_f45_r) * 20'(cfg_wo_r);
    s2_fi_nxt     = 20'(s1_f45_r) * 20'(cfg_wi_r);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < csm_pkg::NCH; i++) begin
        s2_mix_r[i] <= s2_mix_nxt[i];
      end
      s2_fo_r  <= s2_fo_nxt;
      s2_fi_r  <= s2_fi_nxt;
      s2_rsp_r <= s1_rsp_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: gain. The product carries a scale of 100 * 1024.
  // ---------------------------------------------------------------------
  csm_pkg::prod_t     s3_prod_nxt [csm_pkg::NCH];
  csm_pkg::prod_t     s3_prod_r   [csm_pkg::NCH];
  logic [19:0]        s3_fo_r, s3_fi_r;
  logic signed [20:0] s3_rsp_r;

  always_comb begin
    for (int i = 0; i < csm_pkg::NCH; i++) begin
      s3_prod_nxt[i] = s2_mix_r[i] * $signed({1'b0, cfg_gain_r});
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < csm_pkg::NCH; i++) begin
        s3_prod_r[i] <= s3_prod_nxt[i];
      end
      s3_fo_r  <= s2_fo_r;
      s3_fi_r  <= s2_fi_r;
      s3_rsp_r <= s2_rsp_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: saturation check and magnitude. Below the saturation point the
  // magnitude divided by 1024 fits in 19 bits.
  // ---------------------------------------------------------------------
  logic [csm_pkg::NCH-1:0] s4_satp_nxt, s4_satn_nxt, s4_neg_nxt;
  logic [csm_pkg::NCH-1:0] s4_satp_r, s4_satn_r, s4_neg_r;
  logic [18:0]        s4_mag_nxt [csm_pkg::NCH];
  logic [18:0]        s4_mag_r   [csm_pkg::NCH];
  logic [37:0]        abs_p      [csm_pkg::NCH];
  logic [19:0]        s4_fo_r, s4_fi_r;
  logic signed [20:0] s4_rsp_r;

  always_comb begin
    for (int i = 0; i < csm_pkg::NCH; i++) begin
      s4_satp_nxt[i] = s3_prod_r[i] >= csm_pkg::SAT_HI;
      s4_satn_nxt[i] = s3_prod_r[i] <= -csm_pkg::SAT_HI;
      s4_neg_nxt[i]  = s3_prod_r[i][37];
      abs_p[i]       = s3_prod_r[i][37] ? 38'(-s3_prod_r[i]) : 38'(s3_prod_r[i]);
      s4_mag_nxt[i]  = abs_p[i][28:10];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_satp_r <= s4_satp_nxt;
      s4_satn_r <= s4_satn_nxt;
      s4_neg_r  <= s4_neg_nxt;
      for (int i = 0; i < csm_pkg::NCH; i++) begin
        s4_mag_r[i] <= s4_mag_nxt[i];
      end
      s4_fo_r  <= s3_fo_r;
      s4_fi_r  <= s3_fi_r;
      s4_rsp_r <= s3_rsp_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: divide the magnitude by 100 with a reciprocal multiply.
  // ---------------------------------------------------------------------
  logic [csm_pkg::NCH-1:0] s5_satp_r, s5_satn_r, s5_neg_r;
  logic [12:0]        s5_q_r [csm_pkg::NCH];
  logic [19:0]        s5_fo_r, s5_fi_r;
  logic signed [20:0] s5_rsp_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_satp_r <= s4_satp_r;
      s5_satn_r <= s4_satn_r;
      s5_neg_r  <= s4_neg_r;
      for (int i = 0; i < csm_pkg::NCH; i++) begin
        s5_q_r[i] <= csm_pkg::div100(s4_mag_r[i]);
      end
      s5_fo_r  <= s4_fo_r;
      s5_fi_r  <= s4_fi_r;
      s5_rsp_r <= s4_rsp_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: signed, clamped mixer results. The elevons are also taken to
  // hundredths of a centidegree so the spoiler path stays exact.
  // ---------------------------------------------------------------------
  csm_pkg::cmd_t s6_el_nxt [csm_pkg::NCH];
  csm_pkg::cmd_t s6_el_r   [csm_pkg::NCH];
  csm_pkg::sp_t  s6_e100_nxt [2];
  csm_pkg::sp_t  s6_e100_r   [2];
  csm_pkg::sp_t  el_ext      [2];
  logic [19:0]        s6_fo_r, s6_fi_r;
  logic signed [20:0] s6_rsp_r;

  always_comb begin
    for (int i = 0; i < csm_pkg::NCH; i++) begin
      if (s5_satp_r[i]) begin
        s6_el_nxt[i] = csm_pkg::LIMIT_CD;
      end else if (s5_satn_r[i]) begin
        s6_el_nxt[i] = -csm_pkg::LIMIT_CD;
      end else if (s5_neg_r[i]) begin
        s6_el_nxt[i] = -$signed({1'b0, s5_q_r[i]});
      end else begin
        s6_el_nxt[i] = $signed({1'b0, s5_q_r[i]});
      end
    end
    for (int i = 0; i < 2; i++) begin
      el_ext[i]      = 20'(s6_el_nxt[i]);
      s6_e100_nxt[i] = el_ext[i] * 20'sd100;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int i = 0; i < csm_pkg::NCH; i++) begin
        s6_el_r[i] <= s6_el_nxt[i];
      end
      for (int i = 0; i < 2; i++) begin
        s6_e100_r[i] <= s6_e100_nxt[i];
      end
      s6_fo_r  <= s5_fo_r;
      s6_fi_r  <= s5_fi_r;
      s6_rsp_r <= s5_rsp_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: rudder split. Positive rudder opens the right wing pair,
  // anything else the left pair; the other wing keeps its elevon value.
  // Spoiler order is left outer, left inner, right outer, right inner.
  // ---------------------------------------------------------------------
  csm_pkg::sp_t     s7_sp_nxt [csm_pkg::NCH];
  csm_pkg::sp_t     s7_sp_r   [csm_pkg::NCH];
  csm_pkg::sp_wide_t r_w, el_w, er_w;
  csm_pkg::cmd_t    s7_el_r [csm_pkg::NCH];
  logic [19:0]      s7_fo_r, s7_fi_r;

  always_comb begin
    r_w  = 22'(s6_rsp_r);
    el_w = 22'(s6_e100_r[0]);
    er_w = 22'(s6_e100_r[1]);
    if (s6_rsp_r > 21'sd0) begin
      s7_sp_nxt[0] = s6_e100_r[0];
      s7_sp_nxt[1] = s6_e100_r[0];
      s7_sp_nxt[2] = csm_pkg::clamp_sp(er_w + r_w);
      s7_sp_nxt[3] = csm_pkg::clamp_sp(er_w - r_w);
    end else begin
      s7_sp_nxt[0] = csm_pkg::clamp_sp(el_w - r_w);
      s7_sp_nxt[1] = csm_pkg::clamp_sp(el_w + r_w);
      s7_sp_nxt[2] = s6_e100_r[1];
      s7_sp_nxt[3] = s6_e100_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int i = 0; i < csm_pkg::NCH; i++) begin
        s7_sp_r[i] <= s7_sp_nxt[i];
        s7_el_r[i] <= s6_el_r[i];
      end
      s7_fo_r <= s6_fo_r;
      s7_fi_r <= s6_fi_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 8: crow terms, added on the outer spoilers and subtracted on the
  // inner ones. With no flap both terms are zero and nothing changes.
  // ---------------------------------------------------------------------
  csm_pkg::sp_t      s8_sp_nxt [csm_pkg::NCH];
  csm_pkg::sp_t      s8_sp_r   [csm_pkg::NCH];
  csm_pkg::sp_wide_t fo_w, fi_w;
  csm_pkg::cmd_t     s8_el_r [csm_pkg::NCH];

  always_comb begin
    fo_w = $signed({2'b00, s7_fo_r});
    fi_w = $signed({2'b00, s7_fi_r});
    s8_sp_nxt[0] = csm_pkg::clamp_sp(22'(s7_sp_r[0]) + fo_w);
    s8_sp_nxt[1] = csm_pkg::clamp_sp(22'(s7_sp_r[1]) - fi_w);
    s8_sp_nxt[2] = csm_pkg::clamp_sp(22'(s7_sp_r[2]) + fo_w);
    s8_sp_nxt[3] = csm_pkg::clamp_sp(22'(s7_sp_r[3]) - fi_w);
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int i = 0; i < csm_pkg::NCH; i++) begin
        s8_sp_r[i] <= s8_sp_nxt[i];
        s8_el_r[i] <= s7_el_r[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 9: sign and magnitude of each spoiler value.
  // ---------------------------------------------------------------------
  logic [csm_pkg::NCH-1:0] s9_neg_r;
  logic [18:0]   s9_mag_nxt [csm_pkg::NCH];
  logic [18:0]   s9_mag_r   [csm_pkg::NCH];
  logic [19:0]   abs_sp     [csm_pkg::NCH];
  csm_pkg::cmd_t s9_el_r [csm_pkg::NCH];

  always_comb begin
    for (int i = 0; i < csm_pkg::NCH; i++) begin
      abs_sp[i]     = s8_sp_r[i][19] ? 20'(-s8_sp_r[i]) : 20'(s8_sp_r[i]);
      s9_mag_nxt[i] = abs_sp[i][18:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      for (int i = 0; i < csm_pkg::NCH; i++) begin
        s9_neg_r[i] <= s8_sp_r[i][19];
        s9_mag_r[i] <= s9_mag_nxt[i];
        s9_el_r[i]  <= s8_el_r[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 10: back to centidegrees, truncating toward zero.
  // ---------------------------------------------------------------------
  logic [csm_pkg::NCH-1:0] s10_neg_r;
  logic [12:0]   s10_q_r  [csm_pkg::NCH];
  csm_pkg::cmd_t s10_el_r [csm_pkg::NCH];

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s10_neg_r <= s9_neg_r;
      for (int i = 0; i < csm_pkg::NCH; i++) begin
        s10_q_r[i]  <= csm_pkg::div100(s9_mag_r[i]);
        s10_el_r[i] <= s9_el_r[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 11: output register. Disabled spoilers read as zero.
  // ---------------------------------------------------------------------
  csm_pkg::cmd_t s11_sp_nxt [csm_pkg::NCH];
  csm_pkg::cmd_t s11_sp_r   [csm_pkg::NCH];
  csm_pkg::cmd_t s11_el_r   [csm_pkg::NCH];

  always_comb begin
    for (int i = 0; i < csm_pkg::NCH; i++) begin
      if (!cfg_sp_en_r) begin
        s11_sp_nxt[i] = 14'sd0;
      end else if (s10_neg_r[i]) begin
        s11_sp_nxt[i] = -$signed({1'b0, s10_q_r[i]});
      end else begin
        s11_sp_nxt[i] = $signed({1'b0, s10_q_r[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      for (int i = 0; i < csm_pkg::NCH; i++) begin
        s11_sp_r[i] <= s11_sp_nxt[i];
        s11_el_r[i] <= s10_el_r[i];
      end
    end
  end

  assign out_left_elevon         = s11_el_r[0];
  assign out_right_elevon        = s11_el_r[1];
  assign out_vtail_left          = s11_el_r[2];
  assign out_vtail_right         = s11_el_r[3];
  assign out_spoiler_left_outer  = s11_sp_r[0];
  assign out_spoiler_left_inner  = s11_sp_r[1];
  assign out_spoiler_right_outer = s11_sp_r[2];
  assign out_spoiler_right_inner = s11_sp_r[3];

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for control_surface_mixer. Every command beat that the
// mixer accepts has its eight surface values, typed in or worked out by a
// local fixed point model, queued; every result beat is compared field by
// field with the oldest queued entry. The run opens with a short directed
// table, then walks through several register settings with random command
// beats under different amounts of input idling and output back-pressure.
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int HOLD_ITEMS = 60;
  localparam int MAX_REPORTS = 10;

  // Writes to these indexes must be ignored by the block.
  localparam logic [csm_pkg::CFG_IDX_W-1:0] IDX_UNMAPPED_LO = 3'd6;
  localparam logic [csm_pkg::CFG_IDX_W-1:0] IDX_UNMAPPED_HI = 3'd7;

  // Fixed point constants of the mixer arithmetic.
  localparam longint SURF_LIMIT = 4500;
  localparam longint PCT = 100;
  localparam longint GAIN_ONE = 1024;
  localparam longint MIX_DEN = PCT * GAIN_ONE;
  localparam longint CROW_PER_PCT = 45;

  typedef logic signed [7:0] flap_t;

  typedef struct packed {
    csm_pkg::cmd_t ail;
    csm_pkg::cmd_t elev;
    csm_pkg::cmd_t rud;
    flap_t         flap;
  } cmd_set_t;

  typedef struct packed {
    csm_pkg::cmd_t left_elevon;
    csm_pkg::cmd_t right_elevon;
    csm_pkg::cmd_t vtail_left;
    csm_pkg::cmd_t vtail_right;
    csm_pkg::cmd_t sp_left_outer;
    csm_pkg::cmd_t sp_left_inner;
    csm_pkg::cmd_t sp_right_outer;
    csm_pkg::cmd_t sp_right_inner;
  } surfaces_t;

  typedef struct {
    int gain;
    int offset;
    int rate;
    int w_outer;
    int w_inner;
    int enable;
  } mix_settings_t;

  typedef enum {STEP_CHECKED, STEP_PREDICTED, STEP_WRITE} step_kind_t;

  typedef struct {
    step_kind_t                         kind;
    cmd_set_t                           cmds;
    surfaces_t                          want;
    logic [csm_pkg::CFG_IDX_W-1:0]      idx;
    logic [csm_pkg::CFG_DATA_W-1:0]     data;
  } dir_step_t;

  // Every input of the block holds a known value from time zero.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic          in_valid = 1'b0;
  logic          in_ready;
  csm_pkg::cmd_t in_aileron_cmd = '0;
  csm_pkg::cmd_t in_elevator_cmd = '0;
  csm_pkg::cmd_t in_rudder_cmd = '0;
  flap_t         in_flap_pct = '0;

  logic          out_valid;
  logic          out_ready = 1'b0;
  csm_pkg::cmd_t out_left_elevon;
  csm_pkg::cmd_t out_right_elevon;
  csm_pkg::cmd_t out_vtail_left;
  csm_pkg::cmd_t out_vtail_right;
  csm_pkg::cmd_t out_spoiler_left_outer;
  csm_pkg::cmd_t out_spoiler_left_inner;
  csm_pkg::cmd_t out_spoiler_right_outer;
  csm_pkg::cmd_t out_spoiler_right_inner;

  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [csm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [csm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  control_surface_mixer dut (.*);

  // Local copy of the register file, starting from the reset values.
  logic [11:0]        mix_gain = 12'd512;
  logic signed [10:0] mix_offset = '0;
  logic [6:0]         spoil_rate = 7'd100;
  logic [6:0]         crow_outer = '0;
  logic [6:0]         crow_inner = '0;
  logic               spoil_on = 1'b0;

  surfaces_t pending_surfaces[$];
  dir_step_t dir_steps[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int holds_granted = 0;
  int hold_left = 0;
  int mismatches = 0;
  int cycle_count = 0;

  surfaces_t seen;
  surfaces_t want;

  // Phase settings. Row 6 is replaced by random values at run time; the
  // others cover both ends of every register, including values beyond the
  // documented ranges that the block must still take as given.
  mix_settings_t phase_settings [8] = '{
    '{1024,     0, 100,   0,   0, 1},
    '{2048,  1000, 100, 100, 100, 1},
    '{   0, -1000,   0,   0,   0, 1},
    '{4095, -1024, 127, 127, 127, 1},
    '{   1,  1023,  50,  30,  70, 1},
    '{ 700,   -37,  63,  45,  12, 0},
    '{ 512,     0, 100,   0,   0, 1},
    '{ 512,     0, 100,   0,   0, 0}
  };

  // Input idle and output stall percentages, cycled over the phases.
  int idle_modes  [4] = '{0, 86,  0, 35};
  int stall_modes [4] = '{0,  0, 86, 35};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic longint saturate(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Expected surfaces for one command set under the current register copy.
  // Intermediate values stay exact but for the divisions, which truncate
  // toward zero as SystemVerilog's signed division does.
  function automatic surfaces_t mix_surfaces(input cmd_set_t c);
    longint k_elev, k_other, g, em, am, rm, el_l, el_r;
    longint lim, r, fo, fi, lo, li, ro, ri;
    surfaces_t s;
    k_elev = PCT;
    k_other = PCT;
    if (mix_offset < 0) k_elev = PCT - longint'(mix_offset);
    else if (mix_offset > 0) k_other = PCT + longint'(mix_offset);
    g = longint'(mix_gain);
    em = longint'($signed(c.elev)) * k_elev;
    am = longint'($signed(c.ail)) * k_other;
    rm = longint'($signed(c.rud)) * k_other;
    el_l = saturate((em - am) * g / MIX_DEN, SURF_LIMIT);
    el_r = saturate((em + am) * g / MIX_DEN, SURF_LIMIT);
    s.left_elevon = csm_pkg::cmd_t'(el_l);
    s.right_elevon = csm_pkg::cmd_t'(el_r);
    s.vtail_left = csm_pkg::cmd_t'(saturate((em + rm) * g / MIX_DEN, SURF_LIMIT));
    s.vtail_right = csm_pkg::cmd_t'(saturate((em - rm) * g / MIX_DEN, SURF_LIMIT));
    s.sp_left_outer = '0;
    s.sp_left_inner = '0;
    s.sp_right_outer = '0;
    s.sp_right_inner = '0;
    if (spoil_on) begin
      // Spoiler math runs in hundredths of a centidegree.
      lim = SURF_LIMIT * PCT;
      r = longint'($signed(c.rud)) * longint'(spoil_rate);
      lo = el_l * PCT;
      li = lo;
      ro = el_r * PCT;
      ri = ro;
      // Positive rudder splits the right wing, anything else the left one.
      if (r > 0) begin
        ro = saturate(ro + r, lim);
        ri = saturate(ri - r, lim);
      end else begin
        lo = saturate(lo - r, lim);
        li = saturate(li + r, lim);
      end
      // Crow only acts on positive flap.
      if ($signed(c.flap) > 0) begin
        fo = longint'($signed(c.flap)) * CROW_PER_PCT * longint'(crow_outer);
        fi = longint'($signed(c.flap)) * CROW_PER_PCT * longint'(crow_inner);
        lo = saturate(lo + fo, lim);
        li = saturate(li - fi, lim);
        ro = saturate(ro + fo, lim);
        ri = saturate(ri - fi, lim);
      end
      s.sp_left_outer = csm_pkg::cmd_t'(lo / PCT);
      s.sp_left_inner = csm_pkg::cmd_t'(li / PCT);
      s.sp_right_outer = csm_pkg::cmd_t'(ro / PCT);
      s.sp_right_inner = csm_pkg::cmd_t'(ri / PCT);
    end
    return s;
  endfunction

  function automatic string show(input surfaces_t s);
    return $sformatf("elevon %0d/%0d vtail %0d/%0d spoilers L %0d/%0d R %0d/%0d",
                     $signed(s.left_elevon), $signed(s.right_elevon),
                     $signed(s.vtail_left), $signed(s.vtail_right),
                     $signed(s.sp_left_outer), $signed(s.sp_left_inner),
                     $signed(s.sp_right_outer), $signed(s.sp_right_inner));
  endfunction

  // Directed table rows. A checked row carries its expected elevon and
  // V-tail values typed in; spoilers are off in those rows and read zero.
  function automatic dir_step_t checked(input int a, input int e, input int r, input int f,
                                        input int el_l, input int el_r,
                                        input int vt_l, input int vt_r);
    dir_step_t st;
    st.kind = STEP_CHECKED;
    st.cmds = '{csm_pkg::cmd_t'(a), csm_pkg::cmd_t'(e), csm_pkg::cmd_t'(r), flap_t'(f)};
    st.want = '{csm_pkg::cmd_t'(el_l), csm_pkg::cmd_t'(el_r),
                csm_pkg::cmd_t'(vt_l), csm_pkg::cmd_t'(vt_r),
                csm_pkg::cmd_t'(0), csm_pkg::cmd_t'(0),
                csm_pkg::cmd_t'(0), csm_pkg::cmd_t'(0)};
    st.idx = '0;
    st.data = '0;
    return st;
  endfunction

  function automatic dir_step_t predicted(input int a, input int e, input int r,
                                          input int f);
    dir_step_t st;
    st = checked(a, e, r, f, 0, 0, 0, 0);
    st.kind = STEP_PREDICTED;
    return st;
  endfunction

  function automatic dir_step_t reg_write(input logic [csm_pkg::CFG_IDX_W-1:0] idx,
                                          input int data);
    dir_step_t st;
    st = checked(0, 0, 0, 0, 0, 0, 0, 0);
    st.kind = STEP_WRITE;
    st.idx = idx;
    st.data = csm_pkg::CFG_DATA_W'(data);
    return st;
  endfunction

  function automatic csm_pkg::cmd_t rand_cmd();
    case ($urandom_range(9))
      0: return csm_pkg::cmd_t'($urandom);
      1: return ($urandom_range(1) != 0) ? csm_pkg::cmd_t'(SURF_LIMIT)
                                         : -csm_pkg::cmd_t'(SURF_LIMIT);
      2: return '0;
      default: return csm_pkg::cmd_t'(int'($urandom_range(9000)) - 4500);
    endcase
  endfunction

  function automatic flap_t rand_flap();
    case ($urandom_range(4))
      0: return flap_t'($urandom);
      1: return '0;
      default: return flap_t'(int'($urandom_range(200)) - 100);
    endcase
  endfunction

  // One register write beat. Valid stays up between back-to-back writes and
  // drops only after the last one, so it never sees two updates in a step.
  task automatic write_reg(input logic [csm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [csm_pkg::CFG_DATA_W-1:0] data, input logic last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (last) cfg_valid <= 1'b0;
    case (idx)
      csm_pkg::REG_MIXING_GAIN:   mix_gain = data[11:0];
      csm_pkg::REG_MIXING_OFFSET: mix_offset = data[10:0];
      csm_pkg::REG_RUDDER_RATE:   spoil_rate = data[6:0];
      csm_pkg::REG_CROW_OUTER:    crow_outer = data[6:0];
      csm_pkg::REG_CROW_INNER:    crow_inner = data[6:0];
      csm_pkg::REG_SPOILER_EN:    spoil_on = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input mix_settings_t s);
    write_reg(csm_pkg::REG_MIXING_GAIN, csm_pkg::CFG_DATA_W'(s.gain), 1'b0);
    write_reg(csm_pkg::REG_MIXING_OFFSET, csm_pkg::CFG_DATA_W'(s.offset), 1'b0);
    write_reg(csm_pkg::REG_RUDDER_RATE, csm_pkg::CFG_DATA_W'(s.rate), 1'b0);
    write_reg(csm_pkg::REG_CROW_OUTER, csm_pkg::CFG_DATA_W'(s.w_outer), 1'b0);
    write_reg(csm_pkg::REG_CROW_INNER, csm_pkg::CFG_DATA_W'(s.w_inner), 1'b0);
    write_reg(csm_pkg::REG_SPOILER_EN, csm_pkg::CFG_DATA_W'(s.enable), 1'b0);
    // A stray write to an unmapped index must leave everything unchanged.
    write_reg(($urandom_range(1) != 0) ? IDX_UNMAPPED_HI : IDX_UNMAPPED_LO,
              csm_pkg::CFG_DATA_W'($urandom), 1'b1);
  endtask

  // Offer one command beat after a random idle gap and queue its expected
  // result once the mixer takes it. The task is entered right at a clock
  // edge, and valid stays high into the next beat when there is no gap.
  task automatic offer_item(input cmd_set_t c, input surfaces_t expected);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_aileron_cmd <= c.ail;
    in_elevator_cmd <= c.elev;
    in_rudder_cmd <= c.rud;
    in_flap_pct <= c.flap;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_surfaces.push_back(expected);
  endtask

  task automatic wait_drained();
    while (pending_surfaces.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int count);
    cmd_set_t c;
    repeat (count) begin
      c = '{rand_cmd(), rand_cmd(), rand_cmd(), rand_flap()};
      offer_item(c, mix_surfaces(c));
    end
    in_valid <= 1'b0;
    wait_drained();
  endtask

  // Result side. Ready is redrawn every cycle from the current stall rate;
  // each new hold request from the stimulus side blocks the output for a
  // long stretch so the pipeline backs up and stops taking input beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (holds_granted != hold_requests) begin
      holds_granted <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Scoreboard: each result beat is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen = {out_left_elevon, out_right_elevon, out_vtail_left, out_vtail_right,
              out_spoiler_left_outer, out_spoiler_left_inner,
              out_spoiler_right_outer, out_spoiler_right_inner};
      if (pending_surfaces.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result beat: %s", show(seen));
      end else begin
        want = pending_surfaces.pop_front();
        if (seen.left_elevon !== want.left_elevon ||
            seen.right_elevon !== want.right_elevon ||
            seen.vtail_left !== want.vtail_left ||
            seen.vtail_right !== want.vtail_right ||
            seen.sp_left_outer !== want.sp_left_outer ||
            seen.sp_left_inner !== want.sp_left_inner ||
            seen.sp_right_outer !== want.sp_right_outer ||
            seen.sp_right_inner !== want.sp_right_inner) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch at cycle %0d", cycle_count);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(seen));
          end
        end
      end
    end
  end

  initial begin
    dir_step_t st;
    mix_settings_t s;

    // Reset state: gain one half, no offset, spoilers off. These rows show
    // the edges of the command range, saturation in both directions and
    // truncation toward zero of half-step results.
    dir_steps.push_back(checked(0, 0, 0, 0, 0, 0, 0, 0));
    dir_steps.push_back(checked(1000, 2000, 500, 50, 500, 1500, 1250, 750));
    dir_steps.push_back(checked(-4500, 4500, 4500, 100, 4500, 0, 4500, 0));
    dir_steps.push_back(checked(4500, 4500, -4500, -100, 0, 4500, 0, 4500));
    dir_steps.push_back(checked(-8192, 8191, -8192, -128, 4500, 0, 0, 4500));
    dir_steps.push_back(checked(8191, -8192, 8191, 127, -4500, 0, 0, -4500));
    dir_steps.push_back(checked(3, 0, 3, 0, -1, 1, 1, -1));
    // Unity gain with spoilers and full crow on both spoiler pairs.
    dir_steps.push_back(reg_write(csm_pkg::REG_MIXING_GAIN, 1024));
    dir_steps.push_back(reg_write(csm_pkg::REG_SPOILER_EN, 1));
    dir_steps.push_back(reg_write(csm_pkg::REG_CROW_OUTER, 100));
    dir_steps.push_back(reg_write(csm_pkg::REG_CROW_INNER, 100));
    dir_steps.push_back(predicted(0, 0, 1000, 0));
    dir_steps.push_back(predicted(0, 0, -1000, 0));
    dir_steps.push_back(predicted(0, 0, 0, 0));
    dir_steps.push_back(predicted(0, 0, 0, 100));
    dir_steps.push_back(predicted(0, 0, 0, -50));
    dir_steps.push_back(predicted(500, -300, 200, 1));
    dir_steps.push_back(predicted(4500, 4500, 4500, 100));
    dir_steps.push_back(predicted(-4500, -4500, -4500, 100));
    // Negative offset scales the elevator, positive the other inputs.
    dir_steps.push_back(reg_write(csm_pkg::REG_MIXING_OFFSET, -1000));
    dir_steps.push_back(predicted(1000, 2000, -800, 20));
    dir_steps.push_back(predicted(-8192, 8191, 8191, -128));
    dir_steps.push_back(reg_write(csm_pkg::REG_MIXING_OFFSET, 1000));
    dir_steps.push_back(predicted(1000, 2000, -800, 20));
    dir_steps.push_back(predicted(8191, -8192, -8192, 127));
    // Zero gain and zero rudder rate, then values past the stated ranges.
    dir_steps.push_back(reg_write(csm_pkg::REG_RUDDER_RATE, 0));
    dir_steps.push_back(reg_write(csm_pkg::REG_MIXING_OFFSET, 0));
    dir_steps.push_back(reg_write(csm_pkg::REG_MIXING_GAIN, 0));
    dir_steps.push_back(predicted(3000, 3000, 4000, 50));
    dir_steps.push_back(reg_write(IDX_UNMAPPED_LO, 4095));
    dir_steps.push_back(reg_write(csm_pkg::REG_MIXING_GAIN, 4095));
    dir_steps.push_back(reg_write(csm_pkg::REG_RUDDER_RATE, 127));
    dir_steps.push_back(predicted(100, -100, 100, 10));
    // Spoilers off again: the four spoiler outputs must read zero.
    dir_steps.push_back(reg_write(csm_pkg::REG_SPOILER_EN, 0));
    dir_steps.push_back(predicted(1000, 1000, 1000, 100));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < dir_steps.size(); i++) begin
      st = dir_steps[i];
      if (st.kind == STEP_WRITE) begin
        // Registers only change with the pipeline empty.
        if (i == 0 || dir_steps[i-1].kind != STEP_WRITE) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        write_reg(st.idx, st.data,
                  (i + 1 == dir_steps.size()) || (dir_steps[i+1].kind != STEP_WRITE));
      end else if (st.kind == STEP_CHECKED) begin
        offer_item(st.cmds, st.want);
      end else begin
        offer_item(st.cmds, mix_surfaces(st.cmds));
      end
    end
    in_valid <= 1'b0;
    wait_drained();

    // Random phases, each behind a fresh set of register writes.
    for (int p = 0; p < 8; p++) begin
      s = phase_settings[p];
      if (p == 6) begin
        s.gain = $urandom_range(4095);
        s.offset = int'($urandom_range(2047)) - 1024;
        s.rate = $urandom_range(127);
        s.w_outer = $urandom_range(127);
        s.w_inner = $urandom_range(127);
        s.enable = $urandom_range(1);
      end
      apply_settings(s);
      idle_pct = idle_modes[p % 4];
      stall_pct <= stall_modes[p % 4];
      run_phase(ITEMS_PER_PHASE);
      if (p == 1) begin
        // Long output hold while the sender keeps offering beats back to
        // back; the mixer fills and must stall its input. run_phase then
        // waits for every queued result before moving on.
        idle_pct = 0;
        stall_pct <= 0;
        hold_requests <= hold_requests + 1;
        run_phase(HOLD_ITEMS);
      end
    end

    // Let any stray beat past the pipeline depth show up before judging.
    repeat (2 * csm_pkg::NSTG + 4) @(posedge clk);
    if (mismatches == 0 && pending_surfaces.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
